FILE: rtl/mbss_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the masked byte signature scan core
// no dependencies; used by mbss_cell and masked_byte_signature_scan_core
package mbss_pkg;

    // item mode codes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_SCAN    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam int LEN_REG_W = 6;
    localparam int OFFSET_W  = 32;

    // input word
    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] index;
        logic [7:0] pattern_byte;
        logic       wildcard_req;
        logic [7:0] data_byte;
        logic       end_of_image;
    } scan_word_t;

    // result word
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } result_word_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic       scan_en;
        logic       copy_en;
        logic       shift_en;
        logic [7:0] data_byte;
        logic [7:0] pattern_byte;
        logic       wildcard_req;
    } cell_ctrl_t;

endpackage

FILE: rtl/mbss_cell.sv
`timescale 1ns / 1ps
// one cell of the scan chain: a window byte, an aligned window byte and a pattern entry
// depends on mbss_pkg
module mbss_cell (
    input  logic                aclk,
    input  mbss_pkg::cell_ctrl_t ctrl,
    input  logic                load_hit,
    input  logic                is_tail,
    input  logic                in_use,
    input  logic [7:0]          win_in,
    input  logic [7:0]          al_in,
    output logic [7:0]          win_out,
    output logic [7:0]          al_out,
    output logic                hit
);

    logic [7:0] win_reg;
    logic [7:0] win_next;
    logic [7:0] al_reg;
    logic [7:0] al_next;
    logic [7:0] pat_reg;
    logic [7:0] pat_next;
    logic       wild_reg;
    logic       wild_next;
    logic [7:0] al_scan;

    // byte this cell holds after a scan step
    assign al_scan = is_tail ? ctrl.data_byte : al_in;

    // next values of the cell registers
    always_comb begin
        win_next  = win_reg;
        al_next   = al_reg;
        pat_next  = pat_reg;
        wild_next = wild_reg;
        if (ctrl.scan_en) begin
            win_next = win_in;
            al_next  = al_scan;
        end else if (ctrl.copy_en) begin
            al_next = win_reg;
        end else if (ctrl.shift_en) begin
            al_next = al_in;
        end
        if (load_hit) begin
            pat_next  = ctrl.pattern_byte;
            wild_next = ctrl.wildcard_req;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        al_reg   <= al_next;
        pat_reg  <= pat_next;
        wild_reg <= wild_next;
    end

    // match of this position against the byte arriving with the scan
    assign hit     = !in_use || wild_reg || (pat_reg == al_scan);
    assign win_out = win_reg;
    assign al_out  = al_reg;

endmodule

FILE: rtl/masked_byte_signature_scan_core.sv
`timescale 1ns / 1ps
// top level of the masked byte signature scan core: cell chain and search control
// depends on mbss_pkg and mbss_cell
//
// Usage: pattern entries are written with load words (mode 0), image bytes are
// streamed with scan words (mode 1) and a restart word (mode 2) begins a new
// search. Every word travels on the s_ channel, results on the m_ channel, and the
// pattern length register on the cfg channel. A scan word that completes the
// first match gives found=1 with the match's start offset; the end-of-image byte
// with no match gives found=0. Later scan words are dropped until a restart.
// Throughput is one word per clock while s_ready is high: each word is settled in
// the cycle it is accepted, since every cell compares its entry with the byte it
// takes in that cycle. A result appears on m_ in the cycle after the scan word
// that caused it. A held result stalls s_ only while m_ready is low; the output
// register then frees in the same cycle it is taken.
// A cfg write realigns the comparison window in a copy state, then a shift state
// for the unused pattern positions (MAX_PATTERN - length); s_ready is low meanwhile.
// Reset clears the search, the length (to 1) and the output; pattern entries are
// undefined until loaded.
module masked_byte_signature_scan_core #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mbss_pkg::scan_word_t          s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mbss_pkg::result_word_t        m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mbss_pkg::LEN_REG_W-1:0] cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int OW    = mbss_pkg::OFFSET_W;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_COPY,
        ST_SHIFT
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [CNT_W-1:0]                shift_cnt_reg;
    logic [CNT_W-1:0]                shift_cnt_next;
    logic [mbss_pkg::LEN_REG_W-1:0]  plen_reg;
    logic [mbss_pkg::LEN_REG_W-1:0]  plen_next;
    logic [OW-1:0]                   seen_reg;
    logic [OW-1:0]                   seen_next;
    logic                            done_reg;
    logic                            done_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    mbss_pkg::result_word_t          m_data_reg;
    mbss_pkg::result_word_t          m_data_next;

    logic                            s_fire;
    logic                            scan_go;
    logic                            load_go;
    logic                            restart_go;
    logic [LEN_W-1:0]                len_use;
    logic [LEN_W-1:0]                base;
    logic [OW-1:0]                   seen_inc;
    logic                            enough;
    logic                            match;
    mbss_pkg::cell_ctrl_t            ctrl;
    logic [7:0]                      win_q [MAX_PATTERN];
    logic [7:0]                      al_q  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]          hit;

    // length in use: zero reads as one, large values clamp to the chain length
    always_comb begin
        if (plen_reg == '0) begin
            len_use = LEN_W'(1);
        end else if (32'(plen_reg) > 32'(MAX_PATTERN)) begin
            len_use = LEN_W'(MAX_PATTERN);
        end else begin
            len_use = LEN_W'(plen_reg);
        end
        base = LEN_W'(MAX_PATTERN) - len_use;
    end

    // handshakes and item decode
    assign s_ready    = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign cfg_ready  = 1'b1;
    assign s_fire     = s_valid && s_ready;
    assign load_go    = s_fire && (s_data.mode == mbss_pkg::MODE_LOAD);
    assign restart_go = s_fire && (s_data.mode == mbss_pkg::MODE_RESTART);
    assign scan_go    = s_fire && (s_data.mode == mbss_pkg::MODE_SCAN) && !done_reg;

    // saturating byte count and match decision
    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + OW'(1);
    assign enough   = seen_inc >= OW'(len_use);
    assign match    = enough && (&hit);

    // control broadcast to the chain
    always_comb begin
        ctrl.scan_en      = scan_go;
        ctrl.copy_en      = (state_reg == ST_COPY);
        ctrl.shift_en     = (state_reg == ST_SHIFT);
        ctrl.data_byte    = s_data.data_byte;
        ctrl.pattern_byte = s_data.pattern_byte;
        ctrl.wildcard_req = s_data.wildcard_req;
    end

    // chain of cells, oldest byte at cell 0
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [7:0] win_in;
        logic [7:0] al_in;
        logic       load_hit;
        logic       is_tail;
        logic       in_use;

        if (k == MAX_PATTERN - 1) begin : g_last
            assign win_in = s_data.data_byte;
            assign al_in  = s_data.data_byte;
        end else begin : g_mid
            assign win_in = win_q[k+1];
            assign al_in  = al_q[k+1];
        end

        assign load_hit = load_go && (32'(s_data.index) == k);
        assign is_tail  = (LEN_W'(k) == (len_use - LEN_W'(1)));
        assign in_use   = (LEN_W'(k) < len_use);

        mbss_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .load_hit (load_hit),
            .is_tail  (is_tail),
            .in_use   (in_use),
            .win_in   (win_in),
            .al_in    (al_in),
            .win_out  (win_q[k]),
            .al_out   (al_q[k]),
            .hit      (hit[k])
        );
    end

    // next state of search control, realign sequencer and output register
    always_comb begin
        state_next     = state_reg;
        shift_cnt_next = shift_cnt_reg;
        plen_next      = plen_reg;
        seen_next      = seen_reg;
        done_next      = done_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_COPY: begin
                shift_cnt_next = CNT_W'(base);
                state_next     = (base == '0) ? ST_RUN : ST_SHIFT;
            end
            ST_SHIFT: begin
                shift_cnt_next = shift_cnt_reg - CNT_W'(1);
                if (shift_cnt_reg == CNT_W'(1)) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            plen_next  = cfg_data;
            state_next = ST_COPY;
        end

        if (restart_go) begin
            seen_next = '0;
            done_next = 1'b0;
        end

        if (scan_go) begin
            seen_next = seen_inc;
            if (match) begin
                done_next                = 1'b1;
                m_valid_next             = 1'b1;
                m_data_next.found        = 1'b1;
                m_data_next.match_offset = seen_inc - OW'(len_use);
            end else if (s_data.end_of_image) begin
                done_next                = 1'b1;
                m_valid_next             = 1'b1;
                m_data_next.found        = 1'b0;
                m_data_next.match_offset = '0;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            shift_cnt_reg <= '0;
            plen_reg      <= mbss_pkg::LEN_REG_W'(1);
            seen_reg      <= '0;
            done_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            shift_cnt_reg <= shift_cnt_next;
            plen_reg      <= plen_next;
            seen_reg      <= seen_next;
            done_reg      <= done_next;
            m_valid_reg   <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a new result only follows a live scan word
    a_result_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(scan_go))
        else $error("result raised without a scan word");

    // no words taken while the window is realigned
    a_stall_realign: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_RUN) |-> !s_ready)
        else $error("input accepted during realign");

    // a held result always belongs to a finished search
    a_done_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> done_reg)
        else $error("result pending while search still open");

    // a miss carries a zero offset
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.found) |-> (m_data_reg.match_offset == '0))
        else $error("non-zero offset on a miss");

    // a match never starts past the bytes counted so far
    a_offset_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.found) |-> (m_data_reg.match_offset < seen_reg))
        else $error("match offset beyond byte count");

endmodule

FILE: sim/tb_masked_byte_signature_scan_core.sv
`timescale 1ns / 1ps
// self-checking testbench for masked_byte_signature_scan_core: directed words, then random images
// with planted patterns under several idle and stall mixes, checked against an internal predictor
// depends on mbss_pkg and the core RTL
module tb_masked_byte_signature_scan_core;

    localparam int          PATTERN_DEPTH = 32;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          END_CYCLES    = 10;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned WORD_GOAL     = 1025;

    // predictor of the scan core plus the queue of results it still expects
    class signature_scoreboard;
        logic [7:0]                     entry_byte [PATTERN_DEPTH];
        logic                           entry_wild [PATTERN_DEPTH];
        logic [7:0]                     window [PATTERN_DEPTH];
        logic [31:0]                    bytes_in;
        logic                           finished;
        logic [mbss_pkg::LEN_REG_W-1:0] length_reg;
        mbss_pkg::result_word_t         expected_q [$];
        int unsigned                    mismatches;
        int unsigned                    hits;
        int unsigned                    misses;

        function new();
            foreach (window[k]) begin
                entry_byte[k] = '0;
                entry_wild[k] = 1'b0;
                window[k]     = '0;
            end
            bytes_in   = '0;
            finished   = 1'b0;
            length_reg = mbss_pkg::LEN_REG_W'(1);
            mismatches = 0;
            hits       = 0;
            misses     = 0;
        endfunction

        function void set_length(logic [mbss_pkg::LEN_REG_W-1:0] value);
            length_reg = value;
        endfunction

        // zero counts as one, anything past the depth saturates
        function int unsigned length_in_use();
            if (length_reg == 0)
                return 1;
            if (length_reg > PATTERN_DEPTH)
                return PATTERN_DEPTH;
            return 32'(length_reg);
        endfunction

        // newest n window bytes against entries 0..n-1, oldest byte to entry 0
        function bit window_hit(int unsigned n);
            for (int unsigned k = 0; k < n; k++) begin
                if (!entry_wild[k] && entry_byte[k] != window[PATTERN_DEPTH - n + k])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_word(mbss_pkg::scan_word_t w);
            int unsigned            n;
            mbss_pkg::result_word_t r;
            case (w.mode)
                mbss_pkg::MODE_LOAD: begin
                    if (w.index < PATTERN_DEPTH) begin
                        entry_byte[w.index] = w.pattern_byte;
                        entry_wild[w.index] = w.wildcard_req;
                    end
                end
                mbss_pkg::MODE_RESTART: begin
                    foreach (window[k])
                        window[k] = '0;
                    bytes_in = '0;
                    finished = 1'b0;
                end
                mbss_pkg::MODE_SCAN: begin
                    if (!finished) begin
                        for (int k = 0; k < PATTERN_DEPTH - 1; k++)
                            window[k] = window[k + 1];
                        window[PATTERN_DEPTH - 1] = w.data_byte;
                        if (bytes_in != '1)
                            bytes_in++;
                        n = length_in_use();
                        // a match on the last byte wins over the end of the image
                        if (bytes_in >= n && window_hit(n)) begin
                            r.found        = 1'b1;
                            r.match_offset = bytes_in - n;
                            expected_q.push_back(r);
                            finished = 1'b1;
                        end else if (w.end_of_image) begin
                            r.found        = 1'b0;
                            r.match_offset = '0;
                            expected_q.push_back(r);
                            finished = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
            mismatches++;
        endtask

        task check_result(mbss_pkg::result_word_t got);
            mbss_pkg::result_word_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result offset", got.match_offset, '0);
                return;
            end
            want = expected_q.pop_front();
            if (want.found)
                hits++;
            else
                misses++;
            if (got.found !== want.found)
                report_mismatch("found", 32'(got.found), 32'(want.found));
            if (got.match_offset !== want.match_offset)
                report_mismatch("match_offset", got.match_offset, want.match_offset);
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    mbss_pkg::scan_word_t           s_data;
    logic                           m_valid;
    logic                           m_ready;
    mbss_pkg::result_word_t         m_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mbss_pkg::LEN_REG_W-1:0] cfg_data;

    signature_scoreboard  sb;
    int unsigned          src_idle_pct;
    int unsigned          sink_stall_pct;
    int unsigned          word_count;
    int unsigned          length_writes;
    int unsigned          stall_cycles;
    int unsigned          active_len;
    bit                   entry_loaded [PATTERN_DEPTH];
    logic [7:0]           mirror_byte [PATTERN_DEPTH];
    bit                   mirror_wild [PATTERN_DEPTH];

    masked_byte_signature_scan_core #(
        .MAX_PATTERN (PATTERN_DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // handshake monitor feeding the predictor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_length(cfg_data);
            if (s_valid && s_ready)
                sb.note_word(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // don't-care fields are left random
    function automatic mbss_pkg::scan_word_t random_word();
        logic [31:0] bits;
        bits = $urandom;
        return mbss_pkg::scan_word_t'(bits[$bits(mbss_pkg::scan_word_t)-1:0]);
    endfunction

    task automatic send_word(mbss_pkg::scan_word_t w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic load_entry(int unsigned idx, logic [7:0] value, bit wild);
        mbss_pkg::scan_word_t w;
        w              = random_word();
        w.mode         = mbss_pkg::MODE_LOAD;
        w.index        = idx[4:0];
        w.pattern_byte = value;
        w.wildcard_req = wild;
        entry_loaded[idx] = 1'b1;
        mirror_byte[idx]  = value;
        mirror_wild[idx]  = wild;
        send_word(w);
        word_count++;
    endtask

    task automatic scan_byte(logic [7:0] value, bit last);
        mbss_pkg::scan_word_t w;
        w              = random_word();
        w.mode         = mbss_pkg::MODE_SCAN;
        w.data_byte    = value;
        w.end_of_image = last;
        send_word(w);
        word_count++;
    endtask

    task automatic restart_search();
        mbss_pkg::scan_word_t w;
        w      = random_word();
        w.mode = mbss_pkg::MODE_RESTART;
        send_word(w);
        word_count++;
    endtask

    // unused mode word, or a pattern load landing in the middle of a search
    task automatic send_noise();
        mbss_pkg::scan_word_t w;
        if ($urandom_range(1) == 0) begin
            w      = random_word();
            w.mode = MODE_UNUSED;
            send_word(w);
        end else begin
            load_entry($urandom_range(PATTERN_DEPTH - 1), 8'($urandom_range(255)),
                       $urandom_range(99) < 20);
        end
    endtask

    // drop valid, wait for every pending result, then let the pipeline drain
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(logic [mbss_pkg::LEN_REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        length_writes++;
        active_len = (value == 0) ? 1 : ((value > PATTERN_DEPTH) ? PATTERN_DEPTH : 32'(value));
    endtask

    // one image: optional restart and new pattern, then bytes with a planted match most times
    task automatic run_image();
        logic [7:0]  img [$];
        int unsigned span;
        int unsigned pos;
        bit          fresh;
        bit          keep_open;
        if ($urandom_range(99) < 80)
            restart_search();
        fresh = ($urandom_range(1) == 0);
        for (int k = 0; k < active_len; k++) begin
            if (fresh || !entry_loaded[k])
                load_entry(k, 8'($urandom_range(255)), $urandom_range(99) < 20);
        end
        if ($urandom_range(3) == 0)
            load_entry($urandom_range(PATTERN_DEPTH - 1), 8'($urandom_range(255)),
                       $urandom_range(99) < 20);
        span = ($urandom_range(9) == 0) ? $urandom_range(1, active_len + 40)
                                        : $urandom_range(1, active_len + 8);
        // bytes drawn partly from the pattern to give near misses
        img.delete();
        for (int i = 0; i < span; i++) begin
            if ($urandom_range(1) == 0)
                img.push_back(mirror_byte[$urandom_range(active_len - 1)]);
            else
                img.push_back(8'($urandom_range(255)));
        end
        if (span >= active_len && $urandom_range(99) < 70) begin
            pos = $urandom_range(span - active_len);
            for (int k = 0; k < active_len; k++) begin
                if (!mirror_wild[k])
                    img[pos + k] = mirror_byte[k];
            end
        end
        keep_open = ($urandom_range(99) < 8);
        for (int i = 0; i < span; i++) begin
            if ($urandom_range(99) < 4)
                send_noise();
            scan_byte(img[i], (i == span - 1) && !keep_open);
        end
        // stray bytes after the image, normally dropped
        if ($urandom_range(99) < 10)
            scan_byte(8'($urandom_range(255)), $urandom_range(1) == 1);
    endtask

    task automatic run_round(int unsigned round_no);
        logic [mbss_pkg::LEN_REG_W-1:0] value;
        int unsigned                    start_count;
        case (round_no % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
            default: begin src_idle_pct = 24; sink_stall_pct = 24; end
        endcase
        // length extremes first, then mostly short patterns
        case (round_no)
            0: value = 1;
            1: value = 32;
            2: value = 0;
            3: value = 63;
            4: value = 33;
            default: value = mbss_pkg::LEN_REG_W'(($urandom_range(99) < 70)
                                                   ? $urandom_range(1, 8)
                                                   : $urandom_range(0, 63));
        endcase
        settle_block();
        write_length(value);
        start_count = word_count;
        while (word_count - start_count < 50)
            run_image();
    endtask

    initial begin
        int unsigned round_no;
        sb = new();
        s_valid        <= 1'b0;
        s_data         <= '0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        aresetn        <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        word_count     = 0;
        length_writes  = 0;
        active_len     = 1;
        foreach (entry_loaded[k]) begin
            entry_loaded[k] = 1'b0;
            mirror_byte[k]  = '0;
            mirror_wild[k]  = 1'b0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // length 1 after reset: top index, miss then hit, bytes after completion
        load_entry(PATTERN_DEPTH - 1, 8'hFF, 1'b1);
        load_entry(0, 8'h00, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h00, 1'b1);
        send_noise();
        // image ends with no match
        restart_search();
        scan_byte(8'hFF, 1'b1);
        // wildcard entry takes any byte
        restart_search();
        load_entry(0, 8'h7E, 1'b1);
        scan_byte(8'h12, 1'b0);
        // match on the final byte beats the end of the image
        restart_search();
        load_entry(0, 8'h3C, 1'b0);
        scan_byte(8'h3C, 1'b1);

        // length 2: image shorter than the pattern, then a load during a search
        settle_block();
        write_length(mbss_pkg::LEN_REG_W'(2));
        load_entry(1, 8'h55, 1'b0);
        restart_search();
        scan_byte(8'h3C, 1'b1);
        restart_search();
        scan_byte(8'h3C, 1'b0);
        load_entry(1, 8'h66, 1'b0);
        scan_byte(8'h55, 1'b0);
        scan_byte(8'h3C, 1'b0);
        scan_byte(8'h66, 1'b1);

        // random images across the idle and stall mixes
        round_no = 0;
        while (word_count < WORD_GOAL) begin
            run_round(round_no);
            round_no++;
        end

        settle_block();
        repeat (END_CYCLES) @(posedge aclk);
        $display("covered %0d words over %0d pattern length settings", word_count, length_writes);
        $display("images with a match: %0d, images ended without one: %0d", sb.hits, sb.misses);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
